// ===== hw/rtl/irmc_pkg.sv =====
// Shared types, codes and reset constants for the IR remote motor command controller.
package irmc_pkg;

  // Default width of the speed levels and drive outputs
  localparam int LEVEL_BITS_DEF = 8;

  // Configuration register width and count
  localparam int CFG_DATA_BITS = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int RPT_BITS      = 3;

  // Raw remote frame values
  localparam logic [31:0] CODE_REPEAT = 32'd0;
  localparam logic [31:0] CODE_ONOFF  = 32'd3008159488;
  localparam logic [31:0] CODE_FWD    = 32'd2874466048;
  localparam logic [31:0] CODE_BACK   = 32'd3910590208;
  localparam logic [31:0] CODE_STOP   = 32'd3927301888;
  localparam logic [31:0] CODE_UP     = 32'd2941312768;
  localparam logic [31:0] CODE_DOWN   = 32'd3977436928;
  localparam logic [31:0] CODE_MAX    = 32'd3994148608;

  // Register reset values
  localparam logic [CFG_DATA_BITS-1:0] FWD_MAX_RST  = 8'd250;
  localparam logic [CFG_DATA_BITS-1:0] REV_MAX_RST  = 8'd250;
  localparam logic [CFG_DATA_BITS-1:0] FWD_MIN_RST  = 8'd0;
  localparam logic [CFG_DATA_BITS-1:0] REV_MIN_RST  = 8'd0;
  localparam logic [CFG_DATA_BITS-1:0] FWD_DFLT_RST = 8'd100;
  localparam logic [CFG_DATA_BITS-1:0] REV_DFLT_RST = 8'd100;
  localparam logic [CFG_DATA_BITS-1:0] STEP_RST     = 8'd50;
  localparam logic [RPT_BITS-1:0]      RPT_AFTER_RST = 3'd3;
  localparam logic [RPT_BITS-1:0]      RPT_SAT       = 3'd7;

  typedef enum logic [3:0] {
    CMD_REPEAT  = 4'd0,
    CMD_FWD     = 4'd1,
    CMD_BACK    = 4'd2,
    CMD_STOP    = 4'd3,
    CMD_UP      = 4'd4,
    CMD_DOWN    = 4'd5,
    CMD_MAX     = 4'd6,
    CMD_ONOFF   = 4'd7,
    CMD_UNKNOWN = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    MOT_NONE = 2'd0,
    MOT_FWD  = 2'd1,
    MOT_BACK = 2'd2,
    MOT_STOP = 2'd3
  } motion_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FWD_MAX   = 3'd0,
    REG_REV_MAX   = 3'd1,
    REG_FWD_MIN   = 3'd2,
    REG_REV_MIN   = 3'd3,
    REG_FWD_DFLT  = 3'd4,
    REG_REV_DFLT  = 3'd5,
    REG_STEP      = 3'd6,
    REG_RPT_AFTER = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] fwd_max;
    logic [CFG_DATA_BITS-1:0] rev_max;
    logic [CFG_DATA_BITS-1:0] fwd_min;
    logic [CFG_DATA_BITS-1:0] rev_min;
    logic [CFG_DATA_BITS-1:0] fwd_dflt;
    logic [CFG_DATA_BITS-1:0] rev_dflt;
    logic [CFG_DATA_BITS-1:0] step;
    logic [RPT_BITS-1:0]      rpt_after;
  } cfg_t;

  typedef struct packed {
    logic    powered;
    motion_t motion;
    cmd_t    command;
  } stat_t;

endpackage

// ===== hw/rtl/irmc_cfg_regs.sv =====
// Configuration register bank of the IR remote motor command controller.
module irmc_cfg_regs import irmc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_FWD_MAX:   cfg_nxt.fwd_max   = cfg_wdata;
        REG_REV_MAX:   cfg_nxt.rev_max   = cfg_wdata;
        REG_FWD_MIN:   cfg_nxt.fwd_min   = cfg_wdata;
        REG_REV_MIN:   cfg_nxt.rev_min   = cfg_wdata;
        REG_FWD_DFLT:  cfg_nxt.fwd_dflt  = cfg_wdata;
        REG_REV_DFLT:  cfg_nxt.rev_dflt  = cfg_wdata;
        REG_STEP:      cfg_nxt.step      = cfg_wdata;
        REG_RPT_AFTER: cfg_nxt.rpt_after = cfg_wdata[RPT_BITS-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fwd_max   <= FWD_MAX_RST;
      cfg_r.rev_max   <= REV_MAX_RST;
      cfg_r.fwd_min   <= FWD_MIN_RST;
      cfg_r.rev_min   <= REV_MIN_RST;
      cfg_r.fwd_dflt  <= FWD_DFLT_RST;
      cfg_r.rev_dflt  <= REV_DFLT_RST;
      cfg_r.step      <= STEP_RST;
      cfg_r.rpt_after <= RPT_AFTER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/irmc_decode.sv =====
// Raw remote frame to command decoder.
module irmc_decode import irmc_pkg::*; (
  input  logic [31:0] raw_code,
  output cmd_t        cmd
);

  always_comb begin
    case (raw_code)
      CODE_REPEAT: cmd = CMD_REPEAT;
      CODE_FWD:    cmd = CMD_FWD;
      CODE_BACK:   cmd = CMD_BACK;
      CODE_STOP:   cmd = CMD_STOP;
      CODE_UP:     cmd = CMD_UP;
      CODE_DOWN:   cmd = CMD_DOWN;
      CODE_MAX:    cmd = CMD_MAX;
      CODE_ONOFF:  cmd = CMD_ONOFF;
      default:     cmd = CMD_UNKNOWN;
    endcase
  end

endmodule

// ===== hw/rtl/irmc_core.sv =====
// Controller state and per-command update logic.
module irmc_core import irmc_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  cmd_t                  code,
  input  cfg_t                  cfg,
  output logic [LEVEL_BITS-1:0] fwd_drv,
  output logic [LEVEL_BITS-1:0] rev_drv,
  output stat_t                 stat
);

  // Compare width: wide enough for a level, a register and their sum
  localparam int CW = ((LEVEL_BITS > CFG_DATA_BITS) ? LEVEL_BITS : CFG_DATA_BITS) + 1;

  logic                  pwr_r, pwr_nxt;
  motion_t               mot_r, mot_nxt;
  logic [LEVEL_BITS-1:0] fwd_lvl_r, fwd_lvl_nxt;
  logic [LEVEL_BITS-1:0] rev_lvl_r, rev_lvl_nxt;
  logic [RPT_BITS-1:0]   rpt_r, rpt_nxt;
  logic [2:0]            last_r, last_nxt;
  logic [LEVEL_BITS-1:0] fwd_drv_r, fwd_drv_nxt;
  logic [LEVEL_BITS-1:0] rev_drv_r, rev_drv_nxt;

  logic [CW-1:0] fl_x, rl_x, fmax_x, rmax_x, fmin_x, rmin_x, step_x;
  logic [CW-1:0] fwd_sum, rev_sum, fwd_diff, rev_diff;
  logic [LEVEL_BITS-1:0] fwd_up, rev_up, fwd_dn, rev_dn;
  logic [LEVEL_BITS-1:0] fwd_min_l, rev_min_l, fwd_dflt_l, rev_dflt_l, fwd_max_l;
  cmd_t cmd_eff;

  // Saturating step values from the current levels
  always_comb begin
    fl_x     = CW'(fwd_lvl_r);
    rl_x     = CW'(rev_lvl_r);
    fmax_x   = CW'(cfg.fwd_max);
    rmax_x   = CW'(cfg.rev_max);
    fmin_x   = CW'(cfg.fwd_min);
    rmin_x   = CW'(cfg.rev_min);
    step_x   = CW'(cfg.step);
    fwd_sum  = fl_x + step_x;
    rev_sum  = rl_x + step_x;
    fwd_diff = fl_x - fmin_x;
    rev_diff = rl_x - rmin_x;
    fwd_up   = LEVEL_BITS'((fwd_sum > fmax_x) ? fmax_x : fwd_sum);
    rev_up   = LEVEL_BITS'((rev_sum > rmax_x) ? rmax_x : rev_sum);
    fwd_dn   = LEVEL_BITS'((fwd_diff < step_x) ? fmin_x : (fl_x - step_x));
    rev_dn   = LEVEL_BITS'((rev_diff < step_x) ? rmin_x : (rl_x - step_x));
    fwd_min_l  = LEVEL_BITS'(cfg.fwd_min);
    rev_min_l  = LEVEL_BITS'(cfg.rev_min);
    fwd_dflt_l = LEVEL_BITS'(cfg.fwd_dflt);
    rev_dflt_l = LEVEL_BITS'(cfg.rev_dflt);
    fwd_max_l  = LEVEL_BITS'(cfg.fwd_max);
  end

  always_comb begin
    pwr_nxt     = pwr_r;
    mot_nxt     = mot_r;
    fwd_lvl_nxt = fwd_lvl_r;
    rev_lvl_nxt = rev_lvl_r;
    rpt_nxt     = rpt_r;
    last_nxt    = last_r;
    fwd_drv_nxt = fwd_drv_r;
    rev_drv_nxt = rev_drv_r;
    cmd_eff     = code;
    if (!pwr_r) begin
      if (code == CMD_ONOFF) begin
        pwr_nxt = 1'b1;
      end
    end else begin
      if (code == CMD_REPEAT) begin
        if (rpt_r != RPT_SAT) begin
          rpt_nxt = rpt_r + RPT_BITS'(1);
        end
        cmd_eff = (rpt_nxt > cfg.rpt_after) ? cmd_t'({1'b0, last_r}) : CMD_UNKNOWN;
      end else begin
        rpt_nxt = '0;
      end
      case (cmd_eff)
        CMD_FWD: begin
          last_nxt = 3'(CMD_FWD);
          if (mot_r != MOT_FWD) begin
            fwd_lvl_nxt = fwd_dflt_l;
            mot_nxt     = MOT_FWD;
          end
          fwd_drv_nxt = fwd_lvl_nxt;
          rev_drv_nxt = rev_min_l;
        end
        CMD_BACK: begin
          last_nxt = 3'(CMD_BACK);
          if (mot_r != MOT_BACK) begin
            rev_lvl_nxt = rev_dflt_l;
            mot_nxt     = MOT_BACK;
          end
          fwd_drv_nxt = fwd_min_l;
          rev_drv_nxt = rev_lvl_nxt;
        end
        CMD_STOP: begin
          last_nxt    = 3'(CMD_STOP);
          mot_nxt     = MOT_STOP;
          fwd_drv_nxt = '0;
          rev_drv_nxt = '0;
        end
        CMD_UP: begin
          last_nxt = 3'(CMD_UP);
          if (mot_r == MOT_FWD && fl_x < fmax_x) begin
            fwd_lvl_nxt = fwd_up;
            fwd_drv_nxt = fwd_up;
            rev_drv_nxt = rev_min_l;
          end else if (mot_r == MOT_BACK && rl_x < rmax_x) begin
            rev_lvl_nxt = rev_up;
            fwd_drv_nxt = fwd_min_l;
            rev_drv_nxt = rev_up;
          end
        end
        CMD_DOWN: begin
          last_nxt = 3'(CMD_DOWN);
          if (mot_r == MOT_FWD && fl_x > fmin_x) begin
            fwd_lvl_nxt = fwd_dn;
            fwd_drv_nxt = fwd_dn;
            rev_drv_nxt = rev_min_l;
          end else if (mot_r == MOT_BACK && rl_x > rmin_x) begin
            rev_lvl_nxt = rev_dn;
            fwd_drv_nxt = fwd_min_l;
            rev_drv_nxt = rev_dn;
          end
        end
        CMD_MAX: begin
          // Load the forward level only; drives follow on a later forward command if already moving forward
          last_nxt    = 3'(CMD_MAX);
          fwd_lvl_nxt = fwd_max_l;
        end
        CMD_ONOFF: begin
          pwr_nxt     = 1'b0;
          last_nxt    = '0;
          mot_nxt     = MOT_STOP;
          fwd_drv_nxt = '0;
          rev_drv_nxt = '0;
          fwd_lvl_nxt = fwd_dflt_l;
          rev_lvl_nxt = rev_dflt_l;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwr_r     <= 1'b0;
      mot_r     <= MOT_NONE;
      fwd_lvl_r <= LEVEL_BITS'(FWD_DFLT_RST);
      rev_lvl_r <= LEVEL_BITS'(REV_DFLT_RST);
      rpt_r     <= '0;
      last_r    <= '0;
      fwd_drv_r <= '0;
      rev_drv_r <= '0;
    end else if (advance) begin
      pwr_r     <= pwr_nxt;
      mot_r     <= mot_nxt;
      fwd_lvl_r <= fwd_lvl_nxt;
      rev_lvl_r <= rev_lvl_nxt;
      rpt_r     <= rpt_nxt;
      last_r    <= last_nxt;
      fwd_drv_r <= fwd_drv_nxt;
      rev_drv_r <= rev_drv_nxt;
    end
  end

  assign fwd_drv      = fwd_drv_nxt;
  assign rev_drv      = rev_drv_nxt;
  assign stat.powered = pwr_nxt;
  assign stat.motion  = mot_nxt;
  assign stat.command = code;

endmodule

// ===== hw/rtl/ir_remote_motor_command_controller_unit.sv =====
// Top level of the IR remote motor command controller.
// Takes one 32-bit decoded remote frame per transaction and returns one result
// transaction with the motor drive levels, power flag, motion state and the
// command decoded from that frame. A transaction is accepted every cycle when
// the result side keeps up. The frame passes two registers: the input register
// when the frame is accepted, then the command logic and the result register
// once that register is empty or being taken; out_valid rises as it loads.
// The result register frees itself in the cycle it is taken, so a stalled
// result holds off new input only once the input register is also full.
// Write configuration only while no transaction is in flight. Register
// indexes: 0 forward_max, 1 reverse_max, 2 forward_min, 3 reverse_min,
// 4 forward_default, 5 reverse_default, 6 speed_step, 7 repeat_after (3 bits).
module ir_remote_motor_command_controller_unit import irmc_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [31:0]              in_raw_code,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [LEVEL_BITS-1:0]    out_drive_forward,
  output logic [LEVEL_BITS-1:0]    out_drive_reverse,
  output logic                     out_powered,
  output logic [1:0]               out_motion,
  output logic [3:0]               out_command,
  // Configuration write port
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t                  cfg;
  cmd_t                  code;
  stat_t                 stat;
  logic [LEVEL_BITS-1:0] fwd_drv, rev_drv;

  logic        s1_vld_r, s1_vld_nxt;
  logic [31:0] s1_code_r;
  logic        out_vld_r, out_vld_nxt;
  logic        out_free;
  logic        s1_adv;
  logic        in_take;

  logic [LEVEL_BITS-1:0] out_fwd_r, out_rev_r;
  stat_t                 out_stat_r;

  // Result register can load when empty or being taken this cycle
  assign out_free = !out_vld_r || !out_stall;
  // Move the held frame through the command logic into the result register
  assign s1_adv   = s1_vld_r && out_free;
  // Input register refills when empty or when its frame moves on
  assign in_stall = s1_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_take) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: hold unless loaded
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_code_r <= in_raw_code;
    end
    if (s1_adv) begin
      out_fwd_r  <= fwd_drv;
      out_rev_r  <= rev_drv;
      out_stat_r <= stat;
    end
  end

  irmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  irmc_decode u_decode (
    .raw_code (s1_code_r),
    .cmd      (code)
  );

  // Controller state commits only when the transaction moves to the result
  irmc_core #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .code    (code),
    .cfg     (cfg),
    .fwd_drv (fwd_drv),
    .rev_drv (rev_drv),
    .stat    (stat)
  );

  assign out_valid         = out_vld_r;
  assign out_drive_forward = out_fwd_r;
  assign out_drive_reverse = out_rev_r;
  assign out_powered       = out_stat_r.powered;
  assign out_motion        = out_stat_r.motion;
  assign out_command       = out_stat_r.command;

endmodule
